>>> rtl/clsb_pkg.sv
// Shared constants, codes and controller/datapath types of the link set builder.
`default_nettype none
package clsb_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_LINKS    = 1024;

  localparam int OPCODE_W = 2;
  localparam int VERTEX_W = 11;
  localparam int CLASS_W  = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  localparam int VADDR_W = $clog2(MAX_VERTICES);
  localparam int LIDX_W  = $clog2(MAX_LINKS);
  localparam int LCNT_W  = $clog2(MAX_LINKS + 1);

  localparam logic [OPCODE_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED  = 3'd0,
    ST_SAME    = 3'd1,
    ST_DUP     = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5,
    ST_BAD     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_B,
    S_COMPARE,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic    accept;
    logic    map_write;
    logic    clear_links;
    logic    rd_b;
    logic    cap_a;
    logic    cap_b;
    logic    scan_start;
    logic    scan_run;
    logic    append;
    logic    set_status;
    status_t code;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                va_ok;
    logic                vb_ok;
    logic                same_class;
    logic                scan_hit;
    logic                scan_done;
    logic                table_full;
    logic                out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/clsb_item_if.sv
// Request channel: valid/ready handshake with the item payload.
`default_nettype none
interface clsb_item_if
  import clsb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [CLASS_W-1:0]  class_in;

  modport source (output valid, opcode, vertex_a, vertex_b, class_in, input ready);
  modport sink   (input valid, opcode, vertex_a, vertex_b, class_in, output ready);
endinterface
`default_nettype wire

>>> rtl/clsb_result_if.sv
// Result channel: valid/ready handshake with the result payload.
`default_nettype none
interface clsb_result_if
  import clsb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLASS_W-1:0]  link_start;
  logic [CLASS_W-1:0]  link_end;
  logic [COUNT_W-1:0]  link_count;

  modport source (output valid, status, link_start, link_end, link_count, input ready);
  modport sink   (input valid, status, link_start, link_end, link_count, output ready);
endinterface
`default_nettype wire

>>> rtl/clsb_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`default_nettype none
module clsb_ctrl
  import clsb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.opcode == OP_EDGE && stat.va_ok && stat.vb_ok) begin
          state_next = S_READ_B;
        end else begin
          state_next = S_RESP;
        end
      end
      S_READ_B:  state_next = S_COMPARE;
      S_COMPARE: state_next = stat.same_class ? S_RESP : S_SCAN;
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_BAD;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        case (stat.opcode)
          OP_MAP: begin
            cmd.map_write = stat.va_ok;
            cmd.code      = stat.va_ok ? ST_MAPPED : ST_BAD;
          end
          OP_EDGE: begin
            // fetch the source class; rd_b low selects vertex_a
            cmd.set_status = !(stat.va_ok && stat.vb_ok);
            cmd.code       = ST_BAD;
          end
          OP_CLEAR: begin
            cmd.clear_links = 1'b1;
            cmd.code        = ST_CLEARED;
          end
          default: cmd.code = ST_BAD;
        endcase
      end
      S_READ_B: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
      end
      S_COMPARE: begin
        cmd.cap_b      = 1'b1;
        cmd.scan_start = !stat.same_class;
        cmd.set_status = stat.same_class;
        cmd.code       = ST_SAME;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_hit) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_DUP;
        end else if (stat.scan_done) begin
          cmd.set_status = 1'b1;
          cmd.append     = !stat.table_full;
          cmd.code       = stat.table_full ? ST_FULL : ST_ADDED;
        end
      end
      S_RESP: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/clsb_datapath.sv
// Datapath: class map, link table, scan counter and result register.
`default_nettype none
module clsb_datapath
  import clsb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  input  wire logic [OPCODE_W-1:0] opcode,
  input  wire logic [VERTEX_W-1:0] vertex_a,
  input  wire logic [VERTEX_W-1:0] vertex_b,
  input  wire logic [CLASS_W-1:0]  class_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [CLASS_W-1:0]       out_start,
  output logic [CLASS_W-1:0]       out_end,
  output logic [COUNT_W-1:0]       out_count
);

  logic [OPCODE_W-1:0]  op_q;
  logic [VERTEX_W-1:0]  va_q;
  logic [VERTEX_W-1:0]  vb_q;
  logic [CLASS_W-1:0]   cls_q;

  logic [CLASS_W-1:0]   class_mem [MAX_VERTICES];
  logic [CLASS_W-1:0]   class_rd;
  logic [VADDR_W-1:0]   va_addr;
  logic [VADDR_W-1:0]   vb_addr;

  logic [2*CLASS_W-1:0] link_mem [MAX_LINKS];
  logic [2*CLASS_W-1:0] link_rd;
  logic                 link_rd_vld;
  logic [LCNT_W-1:0]    scan_idx;
  logic [LCNT_W-1:0]    links_held;
  logic                 issue;

  logic [CLASS_W-1:0]   cls_start;
  logic [CLASS_W-1:0]   cls_end;
  status_t              res_status;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= opcode;
      va_q  <= vertex_a;
      vb_q  <= vertex_b;
      cls_q <= class_in;
    end
  end

  assign va_addr = VADDR_W'(va_q - 1'b1);
  assign vb_addr = VADDR_W'(vb_q - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.map_write) class_mem[va_addr] <= cls_q;
    class_rd <= class_mem[cmd.rd_b ? vb_addr : va_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cls_start <= '0;
      cls_end   <= '0;
    end else begin
      if (cmd.cap_a) cls_start <= class_rd;
      if (cmd.cap_b) cls_end   <= class_rd;
    end
  end

  // Scan: one read per cycle, compared in the cycle after its address is issued
  assign issue = scan_idx < links_held;

  always_ff @(posedge clk) begin
    if (cmd.append) link_mem[links_held[LIDX_W-1:0]] <= {cls_start, cls_end};
    link_rd <= link_mem[scan_idx[LIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_run && issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_rd_vld <= 1'b0;
      links_held  <= '0;
    end else begin
      link_rd_vld <= cmd.scan_run && issue;
      if (cmd.clear_links) begin
        links_held <= '0;
      end else if (cmd.append) begin
        links_held <= links_held + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) res_status <= cmd.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_start  <= cls_start;
      out_end    <= cls_end;
      out_count  <= COUNT_W'(links_held);
    end
  end

  always_comb begin
    stat.opcode     = op_q;
    stat.va_ok      = (va_q != '0) && (32'(va_q) <= 32'(MAX_VERTICES));
    stat.vb_ok      = (vb_q != '0) && (32'(vb_q) <= 32'(MAX_VERTICES));
    stat.same_class = cls_start == class_rd;
    stat.scan_hit   = link_rd_vld && (link_rd == {cls_start, cls_end});
    stat.scan_done  = !issue && !link_rd_vld;
    stat.table_full = 32'(links_held) >= 32'(MAX_LINKS);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

>>> rtl/condensation_link_set_builder.sv
// Top level of the condensation link set builder.
// Takes one request at a time: map a vertex to a class, examine an edge, or
// clear the link table; each request yields exactly one result. Map, clear
// and rejected requests go from decode straight to the result state; an
// edge reads the classes of both ends, and if they differ it scans the link
// table for a duplicate, stopping early on a hit: a linear scan through its
// single read port at one entry per cycle. The next request can be taken in
// the cycle after the result is loaded, while that result still waits in the
// output register. The class map and link table are not cleared after
// reset; edges must only name vertices whose class has been written.
`default_nettype none
module condensation_link_set_builder
  import clsb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  clsb_item_if.sink     items,
  clsb_result_if.source results
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clsb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  clsb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (items.opcode),
    .vertex_a   (items.vertex_a),
    .vertex_b   (items.vertex_b),
    .class_in   (items.class_in),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_status (results.status),
    .out_start  (results.link_start),
    .out_end    (results.link_end),
    .out_count  (results.link_count)
  );

endmodule
`default_nettype wire

>>> rtl/clsb_checker.sv
// Port-level checks on the link set builder, bound to the top level.
`default_nettype none
module clsb_checker
  import clsb_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_valid,
  input wire logic                item_ready,
  input wire logic                res_valid,
  input wire logic                res_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [CLASS_W-1:0]  link_start,
  input wire logic [CLASS_W-1:0]  link_end,
  input wire logic [COUNT_W-1:0]  link_count
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(link_count))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while another is in progress");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_CLEARED |-> link_count == '0)
    else $error("cleared result reports stored links");

  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_ADDED || status == ST_DUP) |-> link_start != link_end)
    else $error("link inside one class reported as a link");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> 32'(link_count) == 32'(MAX_LINKS))
    else $error("table full reported below capacity");

endmodule

bind condensation_link_set_builder clsb_checker u_clsb_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (items.valid),
  .item_ready (items.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .status     (results.status),
  .link_start (results.link_start),
  .link_end   (results.link_end),
  .link_count (results.link_count)
);
`default_nettype wire

>>> verif/tb_condensation_link_set_builder.sv
// Self-checking testbench for the condensation link set builder.
`timescale 1ns / 1ps
module tb_condensation_link_set_builder;
  import clsb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 370;
  localparam int FILL_CLASSES = 12;
  localparam int POOL_SIZE = 12;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [CLASS_W-1:0]  class_in;
  } link_req_t;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] link_start;
    logic [CLASS_W-1:0] link_end;
    logic [COUNT_W-1:0] link_count;
  } link_result_t;

  class link_set_scoreboard;
    logic [CLASS_W-1:0] class_map [MAX_VERTICES];
    logic [CLASS_W-1:0] link_from [MAX_LINKS];
    logic [CLASS_W-1:0] link_to [MAX_LINKS];
    int unsigned        links_stored;
    link_result_t       awaited_q [$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        status_tally [8];

    function new();
      links_stored = 0;
      mismatches = 0;
      results_seen = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function bit vertex_valid(logic [VERTEX_W-1:0] v);
      return v >= 1 && v <= MAX_VERTICES;
    endfunction

    function void note_request(link_req_t r);
      link_result_t res;
      logic [CLASS_W-1:0] a;
      logic [CLASS_W-1:0] b;
      bit hit;
      res.status = ST_BAD;
      res.link_start = '0;
      res.link_end = '0;
      case (r.opcode)
        OP_MAP: begin
          if (vertex_valid(r.vertex_a)) begin
            class_map[r.vertex_a - 1] = r.class_in;
            res.status = ST_MAPPED;
          end
        end
        OP_EDGE: begin
          if (vertex_valid(r.vertex_a) && vertex_valid(r.vertex_b)) begin
            a = class_map[r.vertex_a - 1];
            b = class_map[r.vertex_b - 1];
            res.link_start = a;
            res.link_end = b;
            if (a == b) begin
              res.status = ST_SAME;
            end else begin
              hit = 0;
              for (int i = 0; i < links_stored; i++)
                if (link_from[i] == a && link_to[i] == b) hit = 1;
              if (hit) begin
                res.status = ST_DUP;
              end else if (links_stored >= MAX_LINKS) begin
                res.status = ST_FULL;
              end else begin
                link_from[links_stored] = a;
                link_to[links_stored] = b;
                links_stored++;
                res.status = ST_ADDED;
              end
            end
          end
        end
        OP_CLEAR: begin
          links_stored = 0;
          res.status = ST_CLEARED;
        end
        default: ;
      endcase
      res.link_count = COUNT_W'(links_stored);
      awaited_q.push_back(res);
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      results_seen++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d start %0d end %0d count %0d",
                   got.status, got.link_start, got.link_end, got.link_count);
        return;
      end
      want = awaited_q.pop_front();
      status_tally[want.status]++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d differs: want st %0d %0d->%0d n %0d, got st %0d %0d->%0d n %0d",
                   results_seen, want.status, want.link_start, want.link_end,
                   want.link_count, got.status, got.link_start, got.link_end,
                   got.link_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  clsb_item_if   items_ch ();
  clsb_result_if results_ch ();

  condensation_link_set_builder uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  link_set_scoreboard sb;
  int unsigned        burst_left;
  int unsigned        requests_sent;
  bit                 hold_wanted;
  bit                 hold_served;
  bit                 is_mapped [MAX_VERTICES + 1];
  int                 mapped_q [$];
  logic [CLASS_W-1:0] class_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold the request; advance once it is taken, then maybe idle.
  task automatic drive_request(input logic [OPCODE_W-1:0] op,
                               input logic [VERTEX_W-1:0] va,
                               input logic [VERTEX_W-1:0] vb,
                               input logic [CLASS_W-1:0] cls);
    link_req_t r;
    r.opcode = op;
    r.vertex_a = va;
    r.vertex_b = vb;
    r.class_in = cls;
    items_ch.valid <= 1'b1;
    items_ch.opcode <= op;
    items_ch.vertex_a <= va;
    items_ch.vertex_b <= vb;
    items_ch.class_in <= cls;
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    sb.note_request(r);
    requests_sent++;
    if (burst_left == 0) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic map_vertex(input int v, input logic [CLASS_W-1:0] cls);
    drive_request(OP_MAP, VERTEX_W'(v), VERTEX_W'($urandom_range(0, 2047)), cls);
    if (v >= 1 && v <= MAX_VERTICES && !is_mapped[v]) begin
      is_mapped[v] = 1;
      mapped_q.push_back(v);
    end
  endtask

  function automatic logic [VERTEX_W-1:0] bad_vertex();
    if ($urandom_range(0, 3) == 0) return '0;
    return VERTEX_W'($urandom_range(MAX_VERTICES + 1, 2047));
  endfunction

  function automatic logic [VERTEX_W-1:0] any_mapped();
    return VERTEX_W'(mapped_q[$urandom_range(0, mapped_q.size() - 1)]);
  endfunction

  task automatic refresh_pool();
    foreach (class_pool[i]) class_pool[i] = CLASS_W'($urandom_range(0, 1023));
  endtask

  // Receiver: stall on its own pattern, plus one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned held;
    link_result_t got;
    mode = 0;
    mode_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
        got.status = status_t'(results_ch.status);
        got.link_start = results_ch.link_start;
        got.link_end = results_ch.link_end;
        got.link_count = results_ch.link_count;
        sb.check_result(got);
      end
      if (hold_wanted && !hold_served) begin
        hold_served = 1;
        results_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0:       results_ch.ready <= 1'b1;
        1:       results_ch.ready <= 1'(($urandom_range(0, 1)));
        default: results_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("timeout: results still outstanding");
    $display("condensation_link_set_builder: mismatch");
    $finish;
  end

  initial begin
    int unsigned useful;
    int unsigned pick;
    int unsigned offset;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
    logic [CLASS_W-1:0] cls;

    sb = new();
    burst_left = 0;
    requests_sent = 0;
    hold_wanted = 0;
    hold_served = 0;
    foreach (is_mapped[i]) is_mapped[i] = 0;
    rst <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.opcode <= OP_MAP;
    items_ch.vertex_a <= '0;
    items_ch.vertex_b <= '0;
    items_ch.class_in <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every opcode, bad vertices, same class, duplicates.
    drive_request(OP_CLEAR, '0, '0, '0);
    map_vertex(1, '0);
    map_vertex(MAX_VERTICES, '1);
    map_vertex(2, '0);
    map_vertex(0, 10'd5);
    map_vertex(MAX_VERTICES + 1, 10'd7);
    map_vertex(2047, '1);
    drive_request(OP_EDGE, 11'd1, 11'd2, '1);
    drive_request(OP_EDGE, 11'd1, 11'(MAX_VERTICES), '0);
    drive_request(OP_EDGE, 11'd2, 11'(MAX_VERTICES), '0);
    drive_request(OP_EDGE, 11'(MAX_VERTICES), 11'd1, '0);
    drive_request(OP_EDGE, '0, 11'd1, '0);
    drive_request(OP_EDGE, 11'd1, 11'(MAX_VERTICES + 1), '0);
    drive_request(OP_EDGE, '1, '1, '1);
    drive_request(OP_UNUSED, '1, '1, '1);
    drive_request(OP_UNUSED, '0, '0, '0);
    drive_request(OP_CLEAR, '1, '1, '1);
    drive_request(OP_EDGE, 11'(MAX_VERTICES), 11'd2, '0);

    // Load every ordered pair of a dozen classes, then push duplicate and same-class edges.
    drive_request(OP_CLEAR, '0, '0, '0);
    offset = $urandom_range(0, 1023);
    for (int k = 0; k < FILL_CLASSES; k++) map_vertex(k + 1, CLASS_W'(offset + 31 * k));
    for (int i = 0; i < FILL_CLASSES; i++)
      for (int j = 0; j < FILL_CLASSES; j++)
        if (i != j)
          drive_request(OP_EDGE, VERTEX_W'(i + 1), VERTEX_W'(j + 1),
                        CLASS_W'($urandom_range(0, 1023)));
    drive_request(OP_EDGE, 11'd1, 11'd2, '0);
    map_vertex(FILL_CLASSES + 1, CLASS_W'(offset));
    drive_request(OP_EDGE, 11'(FILL_CLASSES + 1), 11'd1, '0);
    drive_request(OP_CLEAR, '0, '0, '0);

    // Random: mostly maps into a small class pool and edges between mapped vertices.
    refresh_pool();
    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      if (useful == 150) hold_wanted = 1;
      pick = $urandom_range(0, 99);
      cls = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom_range(0, 1023))
                                         : class_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 4) begin
        drive_request(OP_CLEAR, VERTEX_W'($urandom_range(0, 2047)),
                      VERTEX_W'($urandom_range(0, 2047)), CLASS_W'($urandom_range(0, 1023)));
        refresh_pool();
        useful++;
      end else if (pick < 24) begin
        if ($urandom_range(0, 5) == 0) map_vertex(any_mapped(), cls);
        else map_vertex($urandom_range(1, MAX_VERTICES), cls);
        useful++;
      end else if (pick < 90) begin
        drive_request(OP_EDGE, any_mapped(), any_mapped(), CLASS_W'($urandom_range(0, 1023)));
        useful++;
      end else begin
        // Noise: unused opcode, bad map or an edge with one bad end.
        case ($urandom_range(0, 2))
          0: drive_request(OP_UNUSED, VERTEX_W'($urandom_range(0, 2047)),
                           VERTEX_W'($urandom_range(0, 2047)), cls);
          1: map_vertex(bad_vertex(), cls);
          default: begin
            va = any_mapped();
            vb = bad_vertex();
            if ($urandom_range(0, 1) == 0) drive_request(OP_EDGE, va, vb, cls);
            else drive_request(OP_EDGE, vb, va, cls);
          end
        endcase
      end
    end
    items_ch.valid <= 1'b0;

    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("run covered %0d requests: %0d maps, %0d same-class, %0d duplicate, %0d added",
             requests_sent, sb.status_tally[ST_MAPPED], sb.status_tally[ST_SAME],
             sb.status_tally[ST_DUP], sb.status_tally[ST_ADDED]);
    $display("  %0d dropped on a full table, %0d clears, %0d rejected; %0d results checked",
             sb.status_tally[ST_FULL], sb.status_tally[ST_CLEARED],
             sb.status_tally[ST_BAD], sb.results_seen);
    if (sb.mismatches > 10) $display("%0d further mismatches not shown", sb.mismatches - 10);
    if (sb.mismatches == 0 && sb.awaited_q.size() == 0) begin
      $display("condensation_link_set_builder: match");
    end else begin
      $display("condensation_link_set_builder: mismatch");
    end
    $finish;
  end

endmodule
